/* design/hsv_to_rgb_pkg.sv */
`timescale 1ns / 1ps
// Package for the HSV to RGB converter: request and result types and the
// fixed-point constants of the conversion. No dependencies.
package hsv_to_rgb_pkg;

    // One HSV request and one RGB result.
    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  level;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Hue geometry in 1/64 degree units.
    localparam logic [14:0] HUE_FULL_TURN = 15'd23040;
    localparam logic [14:0] HUE_SECTOR    = 15'd3840;
    localparam logic [14:0] HUE_PAIR      = 15'd7680;

    // Fractions use 255 as 1.0.
    localparam logic [7:0]  FRAC_ONE      = 8'd255;

    // Rounding offset: half of the common denominator 255 * 3840.
    localparam logic [27:0] ROUND_HALF    = 28'd489600;

    // The denominator is 256 * 3825. After the shift by 8, the division by
    // 3825 is a multiply by ceil(2^32 / 3825) and a shift by 32, which is
    // exact for every dividend below 2^20.
    localparam logic [20:0] RECIP_MULT    = 21'd1122868;

endpackage

/* design/hsv_to_rgb_converter_core.sv */
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter: a six-stage fixed-point pipeline.
// Depends on hsv_to_rgb_pkg for the request and result types and constants.
//
// Usage:
//   The hsv channel carries one request (hue in 1/64 degree, saturation and
//   level with 255 as 1.0) under a valid/ready handshake; the rgb channel
//   returns one 8-bit RGB result per request, in request order.
//   A request is registered in stages s1 to s5 and then in the result
//   register before its result is shown on rgb. Throughput is one request
//   per cycle: a new request may enter at every edge while results are
//   taken.
//   The stages are wrap, sector and triangle, chroma terms, level multiply,
//   reciprocal multiply for the rounded division, and the result register;
//   the level and reciprocal multipliers set the stage depth.
//   Hue values from 360 degrees upward wrap by one full turn.
//   Reset clears every stage valid bit, so the pipeline starts empty and
//   hsv_ready is high.
//   When the receiver holds rgb_ready low with a result waiting, the whole
//   pipeline holds: hsv_ready drops and no request is lost or repeated.
module hsv_to_rgb_converter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hsv_valid,
    output logic                hsv_ready,
    input  hsv_to_rgb_pkg::hsv_t hsv,
    output logic                rgb_valid,
    input  logic                rgb_ready,
    output hsv_to_rgb_pkg::rgb_t rgb
);
    import hsv_to_rgb_pkg::*;

    // Pipeline advance: everything moves unless a result waits untaken.
    logic advance;

    // Stage valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic rgb_valid_reg;

    // Stage 1: wrapped hue.
    logic [14:0] s1_hue_reg, s1_hue_next;
    logic [7:0]  s1_sat_reg, s1_lvl_reg;

    // Stage 2: sector and triangle position.
    logic [2:0]  s2_sector_reg, s2_sector_next;
    logic [11:0] s2_tri_reg, s2_tri_next;
    logic [7:0]  s2_sat_reg, s2_lvl_reg;

    // Stage 3: numerator terms before the level multiply.
    logic [19:0] s3_qmid_reg, s3_qmid_next;
    logic [19:0] s3_qlo_reg, s3_qlo_next;
    logic [2:0]  s3_sector_reg;
    logic [7:0]  s3_lvl_reg;

    // Stage 4: rounded numerators divided by 256.
    logic [19:0] s4_ymid_reg, s4_ymid_next;
    logic [19:0] s4_ylo_reg, s4_ylo_next;
    logic [2:0]  s4_sector_reg;
    logic [7:0]  s4_lvl_reg;

    // Stage 5: middle and smallest channels.
    logic [7:0]  s5_mid_reg, s5_mid_next;
    logic [7:0]  s5_lo_reg, s5_lo_next;
    logic [2:0]  s5_sector_reg;
    logic [7:0]  s5_lvl_reg;

    // Output register.
    rgb_t        rgb_reg, rgb_next;

    assign advance   = !rgb_valid_reg || rgb_ready;
    assign hsv_ready = advance;
    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    // Stage 1 logic: bring the hue into one full turn.
    always_comb
    begin
        if (hsv.hue >= HUE_FULL_TURN)
        begin
            s1_hue_next = hsv.hue - HUE_FULL_TURN;
        end
        else
        begin
            s1_hue_next = hsv.hue;
        end
    end

    // Stage 2 logic: find the 60 degree sector and the distance to the
    // nearest even sector boundary.
    always_comb
    begin
        logic [14:0] pair_base;
        logic [14:0] pos;
        priority if (s1_hue_reg < HUE_SECTOR)
        begin
            s2_sector_next = 3'd0;
        end
        else if (s1_hue_reg < 15'(2 * HUE_SECTOR))
        begin
            s2_sector_next = 3'd1;
        end
        else if (s1_hue_reg < 15'(3 * HUE_SECTOR))
        begin
            s2_sector_next = 3'd2;
        end
        else if (s1_hue_reg < 15'(4 * HUE_SECTOR))
        begin
            s2_sector_next = 3'd3;
        end
        else if (s1_hue_reg < 15'(5 * HUE_SECTOR))
        begin
            s2_sector_next = 3'd4;
        end
        else
        begin
            s2_sector_next = 3'd5;
        end
        pair_base = 15'(s2_sector_next[2:1]) * HUE_PAIR;
        pos       = s1_hue_reg - pair_base;
        if (pos >= HUE_SECTOR)
        begin
            s2_tri_next = 12'(HUE_PAIR - pos);
        end
        else
        begin
            s2_tri_next = pos[11:0];
        end
    end

    // Stage 3 logic: (255 - s) * 3840 for the smallest channel, plus s * t
    // for the middle one.
    always_comb
    begin
        logic [7:0] inv_sat;
        inv_sat      = FRAC_ONE - s2_sat_reg;
        s3_qlo_next  = 20'(inv_sat) * 20'(HUE_SECTOR);
        s3_qmid_next = s3_qlo_next + 20'(s2_sat_reg) * 20'(s2_tri_reg);
    end

    // Stage 4 logic: scale by the level, add half the denominator, and drop
    // the power-of-two factor of the denominator.
    always_comb
    begin
        logic [27:0] num_mid;
        logic [27:0] num_lo;
        num_mid      = 28'(s3_lvl_reg) * 28'(s3_qmid_reg) + ROUND_HALF;
        num_lo       = 28'(s3_lvl_reg) * 28'(s3_qlo_reg) + ROUND_HALF;
        s4_ymid_next = num_mid[27:8];
        s4_ylo_next  = num_lo[27:8];
    end

    // Stage 5 logic: divide by 3825 through the reciprocal multiply.
    always_comb
    begin
        logic [40:0] prod_mid;
        logic [40:0] prod_lo;
        prod_mid    = 41'(s4_ymid_reg) * 41'(RECIP_MULT);
        prod_lo     = 41'(s4_ylo_reg) * 41'(RECIP_MULT);
        s5_mid_next = prod_mid[39:32];
        s5_lo_next  = prod_lo[39:32];
    end

    // Output logic: place largest, middle and smallest channel by sector.
    always_comb
    begin
        unique case (s5_sector_reg)
            3'd0:
            begin
                rgb_next.red   = s5_lvl_reg;
                rgb_next.green = s5_mid_reg;
                rgb_next.blue  = s5_lo_reg;
            end
            3'd1:
            begin
                rgb_next.red   = s5_mid_reg;
                rgb_next.green = s5_lvl_reg;
                rgb_next.blue  = s5_lo_reg;
            end
            3'd2:
            begin
                rgb_next.red   = s5_lo_reg;
                rgb_next.green = s5_lvl_reg;
                rgb_next.blue  = s5_mid_reg;
            end
            3'd3:
            begin
                rgb_next.red   = s5_lo_reg;
                rgb_next.green = s5_mid_reg;
                rgb_next.blue  = s5_lvl_reg;
            end
            3'd4:
            begin
                rgb_next.red   = s5_mid_reg;
                rgb_next.green = s5_lo_reg;
                rgb_next.blue  = s5_lvl_reg;
            end
            default:
            begin
                rgb_next.red   = s5_lvl_reg;
                rgb_next.green = s5_lo_reg;
                rgb_next.blue  = s5_mid_reg;
            end
        endcase
    end

    // Valid bits travel with the data and hold while the pipeline stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= hsv_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            rgb_valid_reg <= s5_valid_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_hue_reg    <= s1_hue_next;
            s1_sat_reg    <= hsv.saturation;
            s1_lvl_reg    <= hsv.level;
            s2_sector_reg <= s2_sector_next;
            s2_tri_reg    <= s2_tri_next;
            s2_sat_reg    <= s1_sat_reg;
            s2_lvl_reg    <= s1_lvl_reg;
            s3_qmid_reg   <= s3_qmid_next;
            s3_qlo_reg    <= s3_qlo_next;
            s3_sector_reg <= s2_sector_reg;
            s3_lvl_reg    <= s2_lvl_reg;
            s4_ymid_reg   <= s4_ymid_next;
            s4_ylo_reg    <= s4_ylo_next;
            s4_sector_reg <= s3_sector_reg;
            s4_lvl_reg    <= s3_lvl_reg;
            s5_mid_reg    <= s5_mid_next;
            s5_lo_reg     <= s5_lo_next;
            s5_sector_reg <= s4_sector_reg;
            s5_lvl_reg    <= s4_lvl_reg;
            rgb_reg       <= rgb_next;
        end
    end

`ifndef SYNTHESIS
    // The sector count stays within the six sectors of a full turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_sector_reg <= 3'd5))
    else $error("hue sector out of range");

    // The triangle position never passes one sector width.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (15'(s2_tri_reg) <= HUE_SECTOR))
    else $error("triangle position out of range");

    // The middle-channel term never exceeds the full denominator share, and the smallest-channel term never exceeds it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_qmid_reg <= 20'(255 * 3840)) && (s3_qlo_reg <= s3_qmid_reg))
    else $error("chroma term out of range");

    // Smallest never exceeds middle, and middle never exceeds the level.
    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_lo_reg <= s5_mid_reg) && (s5_mid_reg <= s5_lvl_reg))
    else $error("channel ordering broken");
`endif

endmodule
